// ===== rtl/fbt_pkg.sv =====
// Package for the flow block table: command and status codes, payload types, hash constants, FSM states.
package fbt_pkg;

	typedef enum logic [2:0] {
		CMD_ADD   = 3'd0,
		CMD_CHECK = 3'd1,
		CMD_START = 3'd2,
		CMD_ARM   = 3'd3,
		CMD_TICK  = 3'd4
	} cmd_t;

	localparam logic [1:0] ST_DONE    = 2'd0;
	localparam logic [1:0] ST_IGNORED = 2'd1;
	localparam logic [1:0] ST_PRESENT = 2'd2;
	localparam logic [1:0] ST_FULL    = 2'd3;

	localparam logic [7:0]  PROTO_TCP = 8'd6;
	localparam logic [7:0]  PROTO_UDP = 8'd17;
	localparam logic [63:0] MIX_MULT  = 64'h9E3779B97F4A7C15;
	localparam logic [31:0] MIX_LO    = MIX_MULT[31:0];
	localparam logic [31:0] MIX_HI    = MIX_MULT[63:32];
	localparam int          KEY_W     = 41;
	localparam int          TUPLE_W   = 4 * 64 + KEY_W;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [63:0] src_addr_hi;
		logic [63:0] src_addr_lo;
		logic [63:0] dst_addr_hi;
		logic [63:0] dst_addr_lo;
		logic [15:0] src_port;
		logic [15:0] dst_port;
		logic [7:0]  protocol;
		logic        is_ipv6;
	} in_item_t;

	typedef struct packed {
		logic       drop;
		logic [1:0] status;
		logic       purged;
	} out_item_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_SHF,
		S_QUOT,
		S_REM,
		S_READ,
		S_CMP,
		S_DONE
	} state_t;

endpackage

// ===== rtl/flow_block_table.sv =====
// Flow block table top level: hashed exact-match table of blocked connection tuples.
// One command is handled at a time. The tuple hash takes five 64-bit mixing rounds, each
// split into a multiply state (three 32x32 partial products) and a sum/shift/xor state;
// the bucket index then takes a quotient state (reciprocal multiply) and a remainder
// state (multiply-subtract). The ways of the bucket are read one at a time from the
// tuple RAM, which has registered read data: each read state is followed by a compare
// state for that way, and a completion state then loads the result register. Start,
// arm and tick go from their transfer straight to the completion state. The block takes
// the next command in the same cycle the result appears, at the edge where that result
// transfers; a result that waits stalled holds off the next command. Valid bits live in
// flip-flops and all clear together on purge, so there is no clearing pass after reset.
module flow_block_table
	import fbt_pkg::*;
#(
	parameter int BUCKETS = 64,
	parameter int WAYS    = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_item_t    in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_item_t   out_data
);
	localparam int ENTRIES = BUCKETS * WAYS;
	localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int BW      = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int WW      = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int WCW     = $clog2(WAYS + 1);
	// reciprocal for exact 32-bit division by BUCKETS: ceil(2^(32+DSH) / BUCKETS)
	localparam int          DSH     = $clog2(BUCKETS);
	localparam logic [63:0] RECIP_W = ((64'd1 << (32 + DSH)) + 64'(BUCKETS) - 64'd1)
		/ 64'(BUCKETS);
	localparam logic [32:0] RECIP   = RECIP_W[32:0];

	state_t state_q, state_d;

	logic [15:0]        period_q;
	logic [7:0]         block_cnt_q;
	logic [15:0]        countdown_q;
	logic               armed_q;
	logic [ENTRIES-1:0] valid_q;

	in_item_t           item_q;
	logic [63:0]        h_q, plo_q;
	logic [31:0]        pmid_a_q, pmid_b_q;
	logic [31:0]        quot_q;
	logic [2:0]         round_q;
	logic [BW-1:0]      bucket_q;
	logic [WCW-1:0]     way_q;
	logic               hit_q, free_found_q;
	logic [WW-1:0]      free_way_q;
	out_item_t          res_q;
	logic               out_valid_q;

	logic [KEY_W-1:0]   key;
	logic [TUPLE_W-1:0] tuple, rd_tuple;
	logic [63:0]        word, mul_in, prod, mixed;
	logic [64:0]        recip_prod;
	logic [31:0]        rem;
	logic               rd_valid_s1;
	logic [AW-1:0]      raddr, waddr;
	logic               ram_we;
	logic               accept, res_load;
	out_item_t          res_d;

	assign key   = {item_q.is_ipv6, item_q.protocol, item_q.dst_port, item_q.src_port};
	assign tuple = {item_q.src_addr_hi, item_q.src_addr_lo, item_q.dst_addr_hi,
		item_q.dst_addr_lo, key};

	always_comb begin
		unique case (round_q)
			3'd0:    word = item_q.src_addr_hi;
			3'd1:    word = item_q.src_addr_lo;
			3'd2:    word = item_q.dst_addr_hi;
			3'd3:    word = item_q.dst_addr_lo;
			default: word = {23'd0, key};
		endcase
	end

	// low 64 bits of the product from three partials; the high-by-high term drops out
	assign mul_in = h_q ^ word;
	assign prod   = plo_q + {pmid_a_q + pmid_b_q, 32'd0};
	assign mixed  = prod ^ (prod >> 29);

	// bucket = top half of the hash mod BUCKETS
	assign recip_prod = 65'(h_q[63:32]) * 65'(RECIP);
	assign rem        = h_q[63:32] - quot_q * 32'(BUCKETS);

	// bucket index and way to address
	assign raddr = AW'(bucket_q) * AW'(WAYS) + AW'(way_q[WW-1:0]);
	assign waddr = AW'(bucket_q) * AW'(WAYS) + AW'(free_way_q);

	assign accept    = in_valid && !in_stall;
	// a waiting result holds off the next command unless it transfers at this edge
	assign in_stall  = (state_q != S_IDLE) || (out_valid_q && out_stall);
	assign res_load  = (state_q == S_DONE);
	assign out_valid = out_valid_q;
	assign out_data  = res_q;

	assign ram_we = res_load && (item_q.cmd == CMD_ADD) && !hit_q && free_found_q
		&& (item_q.protocol == PROTO_TCP || item_q.protocol == PROTO_UDP);

	fbt_ram #(.WIDTH(TUPLE_W), .DEPTH(ENTRIES)) u_tuple_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (waddr),
		.wdata (tuple),
		.raddr (raddr),
		.rdata (rd_tuple)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (accept) begin
				state_d = (in_data.cmd == CMD_ADD || in_data.cmd == CMD_CHECK) ? S_MUL : S_DONE;
			end
			S_MUL:  state_d = S_SHF;
			S_SHF:  state_d = (round_q == 3'd4) ? S_QUOT : S_MUL;
			S_QUOT: state_d = S_REM;
			S_REM:  state_d = S_READ;
			S_READ: state_d = S_CMP;
			S_CMP:  state_d = (way_q == WCW'(WAYS - 1)) ? S_DONE : S_READ;
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q  <= in_data;
			h_q     <= '0;
			round_q <= '0;
			way_q   <= '0;
		end
		if (state_q == S_MUL) begin
			plo_q    <= 64'(mul_in[31:0]) * 64'(MIX_LO);
			pmid_a_q <= mul_in[31:0] * MIX_HI;
			pmid_b_q <= mul_in[63:32] * MIX_LO;
		end
		if (state_q == S_SHF) begin
			h_q     <= mixed;
			round_q <= round_q + 3'd1;
		end
		if (state_q == S_QUOT) begin
			quot_q <= 32'(recip_prod >> (32 + DSH));
		end
		if (state_q == S_REM) begin
			bucket_q <= rem[BW-1:0];
		end
		if (state_q == S_READ) begin
			rd_valid_s1 <= valid_q[raddr];
		end
		if (state_q == S_CMP) begin
			way_q <= way_q + WCW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q        <= 1'b0;
			free_found_q <= 1'b0;
			free_way_q   <= '0;
		end else if (accept) begin
			hit_q        <= 1'b0;
			free_found_q <= 1'b0;
			free_way_q   <= '0;
		end else if (state_q == S_CMP) begin
			if (!rd_valid_s1) begin
				if (!free_found_q) begin
					free_found_q <= 1'b1;
					free_way_q   <= way_q[WW-1:0];
				end
			end else if (rd_tuple == tuple) begin
				hit_q <= 1'b1;
			end
		end
	end

	// result of the command in hand
	always_comb begin
		res_d = '0;
		unique case (item_q.cmd)
			CMD_ADD: begin
				if (item_q.protocol != PROTO_TCP && item_q.protocol != PROTO_UDP) begin
					res_d.status = ST_IGNORED;
				end else if (hit_q) begin
					res_d.status = ST_PRESENT;
				end else if (!free_found_q) begin
					res_d.status = ST_FULL;
				end else begin
					res_d.status = ST_DONE;
				end
			end
			CMD_CHECK: res_d.drop = (block_cnt_q != 8'd0) && hit_q;
			CMD_TICK:  res_d.purged = armed_q && (countdown_q <= 16'd1);
			default: ;
		endcase
	end

	// control state and result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q    <= 16'd1000;
			block_cnt_q <= '0;
			countdown_q <= '0;
			armed_q     <= 1'b0;
			valid_q     <= '0;
			out_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			if (cfg_we) begin
				period_q <= cfg_wdata;
			end
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (ram_we) begin
				valid_q[waddr] <= 1'b1;
			end
			if (res_load) begin
				res_q <= res_d;
				unique case (item_q.cmd)
					CMD_START: if (block_cnt_q != 8'd255) begin
						block_cnt_q <= block_cnt_q + 8'd1;
					end
					CMD_ARM: begin
						countdown_q <= period_q;
						armed_q     <= 1'b1;
					end
					CMD_TICK: if (armed_q) begin
						if (countdown_q <= 16'd1) begin
							countdown_q <= '0;
							armed_q     <= 1'b0;
							valid_q     <= '0;
							if (block_cnt_q != 8'd0) begin
								block_cnt_q <= block_cnt_q - 8'd1;
							end
						end else begin
							countdown_q <= countdown_q - 16'd1;
						end
					end
					default: ;
				endcase
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> state_q == S_DONE)
		else $error("tuple write outside completion");
	assert property (@(posedge clk) disable iff (!arst_n)
		res_load |=> out_valid)
		else $error("result lost");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> in_stall)
		else $error("transfer taken while busy");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");
endmodule

// ===== rtl/fbt_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
module fbt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
